// File: rtl/assert_macros.svh
// Assertion macros used by the checker file ftb_chk.sv.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ftb_pkg.sv
// Types and constants of the frequency/time balancer.
// No dependencies; the files that use it refer to it by scoped names.
package ftb_pkg;

  localparam logic [1:0] OP_DOMAIN   = 2'd0;
  localparam logic [1:0] OP_LIMIT    = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic CFG_MIN_FREQ = 1'b0;
  localparam logic CFG_MAX_FREQ = 1'b1;

  localparam logic [15:0] MIN_FREQ_RST = 16'd800;
  localparam logic [15:0] MAX_FREQ_RST = 16'd3000;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] elapsed_time;
    logic        time_recorded;
    logic [15:0] requested_freq;
    logic [15:0] achieved_freq;
    logic [6:0]  high_priority_count;
    logic [15:0] high_priority_freq;
    logic [15:0] low_priority_freq;
  } in_t;

  typedef struct packed {
    logic [5:0]  domain_index;
    logic [15:0] desired_freq;
    logic [31:0] target_time;
    logic        last;
  } out_t;

  typedef enum logic [1:0] {
    K_DOM = 2'd0,
    K_LIM = 2'd1,
    K_CMP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    in_t   word;
  } cmd_t;

  typedef struct packed {
    logic [15:0] min_freq;
    logic [15:0] max_freq;
  } cfg_t;

  function automatic logic [31:0] sat32(input logic [47:0] q);
    sat32 = (q > {16'd0, SAT32}) ? SAT32 : q[31:0];
  endfunction

  function automatic logic [15:0] clamp16(input logic [47:0] v, input logic [15:0] lo,
                                          input logic [15:0] hi);
    logic [47:0] x;
    x = (v < {32'd0, lo}) ? {32'd0, lo} : v;
    clamp16 = (x > {32'd0, hi}) ? hi : x[15:0];
  endfunction

endpackage

// File: rtl/ftb_front.sv
// Front end: accepts input words, classifies them and queues commands.
// Depends on ftb_pkg.
module ftb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  ftb_pkg::in_t  in_word,
  output logic          cmd_valid,
  output ftb_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  ftb_pkg::cmd_t ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          keep;
  ftb_pkg::cmd_t cls;

  always_comb begin
    cls.word = in_word;
    keep     = 1'b1;
    case (in_word.opcode)
      ftb_pkg::OP_DOMAIN:  cls.kind = ftb_pkg::K_DOM;
      ftb_pkg::OP_LIMIT:   cls.kind = ftb_pkg::K_LIM;
      ftb_pkg::OP_COMPUTE: cls.kind = ftb_pkg::K_CMP;
      default: begin
        cls.kind = ftb_pkg::K_CMP;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rp_r];

  logic do_wr, do_rd;
  assign do_wr = in_push && !in_full && keep;
  assign do_rd = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) begin
        ent_r[wp_r] <= cls;
        wp_r        <= ~wp_r;
      end
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

// File: rtl/ftb_div.sv
// Restoring divider, one quotient bit per cycle; zero divisor gives all ones.
// Depends on nothing.
module ftb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [47:0] quo
);

  localparam int STEPS = 48;
  localparam int CTW   = $clog2(STEPS + 1);

  logic [47:0]    quo_r;
  logic [31:0]    rem_r, den_r;
  logic [CTW-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [32:0]    trial, diff;
  logic           ge;

  assign trial = {rem_r, quo_r[47]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CTW'(STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[31:0] : trial[31:0];
        quo_r <= {quo_r[46:0], ge};
        cnt_r <= cnt_r - CTW'(1);
        if (cnt_r == CTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/ftb_back.sv
// Back end: domain and limit stores, ranking, target search and rescaling.
// Depends on ftb_pkg and ftb_div.
module ftb_back #(
  parameter int MAX_DOMAINS = 64,
  parameter int MAX_LIMITS  = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ftb_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  ftb_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          oq_full,
  output logic          oq_push,
  output ftb_pkg::out_t oq_word
);

  localparam int IW  = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
  localparam int CW  = $clog2(MAX_DOMAINS + 1);
  localparam int LIW = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1;
  localparam int LW  = $clog2(MAX_LIMITS + 1);

  typedef struct packed {
    logic        rec;
    logic [15:0] req;
    logic [31:0] tim;
    logic [47:0] work;
  } drec_t;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_LOAD = 19'h00002,
    S_RK_I = 19'h00004,
    S_RK_C = 19'h00008,
    S_RK_J = 19'h00010,
    S_RK_W = 19'h00020,
    S_SCAN = 19'h00040,
    S_TGT  = 19'h00080,
    S_LIM  = 19'h00100,
    S_HP_W = 19'h00200,
    S_LP_W = 19'h00400,
    S_P1R  = 19'h00800,
    S_P1D  = 19'h01000,
    S_P1W  = 19'h02000,
    S_P2R  = 19'h04000,
    S_P2D  = 19'h08000,
    S_P2W  = 19'h10000,
    S_EMR  = 19'h20000,
    S_EMD  = 19'h40000
  } state_t;

  state_t state_r;

  drec_t       rec_mem  [MAX_DOMAINS];
  logic [IW-1:0] rank_mem [MAX_DOMAINS];
  logic [15:0] des_mem  [MAX_DOMAINS];
  drec_t       rd_rec_r;
  logic [IW-1:0] rd_rank_r;
  logic [15:0] rd_des_r;
  logic [IW-1:0] rd_addr;

  logic [CW-1:0] dcnt_r, i_r, j_r, pj_r;
  logic          pv_r;
  logic [LW-1:0] lcnt_r, k_r;
  logic [6:0]    lim_cnt_r [MAX_LIMITS];
  logic [15:0]   lim_frq_r [MAX_LIMITS];
  logic [47:0]   lpw_r [MAX_LIMITS];
  logic          lpr_r [MAX_LIMITS];
  drec_t         ld_r;
  logic [15:0]   lpf_r;
  logic [IW-1:0] cnt_r;
  logic          ci_rec_r;
  logic [47:0]   ci_work_r;
  logic          lag_rec_r, ref_found_r, any_unl_r;
  logic [47:0]   lag_work_r;
  logic [31:0]   lag_time_r, ref_time_r, target_r, hp_r;
  logic [IW-1:0] best_rank_r;
  logic [15:0]   cutoff_r, group_r, d_r;

  logic          dst_r;
  logic [47:0]   div_num_r;
  logic [31:0]   div_den_r;
  logic          div_done;
  logic [47:0]   div_quo;

  ftb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dst_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic [LIW-1:0] klim;
  logic           issue, last_pj, ahead, unl_j;
  logic [CW-1:0]  n_m1;
  logic [31:0]    quo32, proj_lp;
  logic [15:0]    d1, s2, hi2;
  logic           des_we;
  logic [15:0]   des_wd;

  assign klim    = k_r[LIW-1:0];
  assign n_m1    = dcnt_r - CW'(1);
  assign issue   = (j_r < dcnt_r);
  assign last_pj = pv_r && (pj_r == n_m1);
  assign unl_j   = (rd_rec_r.req >= cfg.max_freq);
  assign quo32   = ftb_pkg::sat32(div_quo);
  assign proj_lp = (quo32 > hp_r) ? quo32 : hp_r;
  assign d1      = ftb_pkg::clamp16(div_quo, cfg.min_freq, cfg.max_freq);
  assign hi2     = (d_r > cutoff_r) ? cfg.max_freq : cutoff_r;
  assign s2      = ftb_pkg::clamp16(div_quo, cfg.min_freq, hi2);

  always_comb begin
    if (rd_rec_r.rec != ci_rec_r) ahead = rd_rec_r.rec;
    else if (rd_rec_r.rec && (rd_rec_r.work != ci_work_r)) ahead = rd_rec_r.work > ci_work_r;
    else ahead = (pj_r < i_r);
  end

  always_comb begin
    if (state_r == S_RK_J || state_r == S_SCAN) rd_addr = j_r[IW-1:0];
    else rd_addr = i_r[IW-1:0];
  end

  always_comb begin
    des_we = 1'b0;
    des_wd = rd_rec_r.req;
    case (state_r)
      S_P1D: des_we = !rd_rec_r.rec;
      S_P1W: begin
        des_we = div_done;
        des_wd = d1;
      end
      S_P2W: begin
        des_we = div_done;
        des_wd = s2;
      end
      default: des_we = 1'b0;
    endcase
  end

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;
  assign oq_push = (state_r == S_EMD) && !oq_full;
  assign oq_word.domain_index = 6'(i_r);
  assign oq_word.desired_freq = any_unl_r ? rd_des_r : cfg.max_freq;
  assign oq_word.target_time  = target_r;
  assign oq_word.last         = (i_r == n_m1);

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) rec_mem[dcnt_r[IW-1:0]] <= ld_r;
    rd_rec_r <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RK_W) rank_mem[i_r[IW-1:0]] <= cnt_r;
    rd_rank_r <= rank_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (des_we) des_mem[i_r[IW-1:0]] <= des_wd;
    rd_des_r <= des_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dcnt_r  <= '0;
      lcnt_r  <= '0;
      dst_r   <= 1'b0;
    end else begin
      dst_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              ftb_pkg::K_DOM: begin
                if (dcnt_r < CW'(MAX_DOMAINS)) begin
                  ld_r.rec  <= cmd.word.time_recorded;
                  ld_r.req  <= cmd.word.requested_freq;
                  ld_r.tim  <= cmd.word.elapsed_time;
                  ld_r.work <= cmd.word.elapsed_time * 48'(cmd.word.achieved_freq);
                  state_r   <= S_LOAD;
                end
              end
              ftb_pkg::K_LIM: begin
                if (lcnt_r < LW'(MAX_LIMITS)) begin
                  lim_cnt_r[lcnt_r[LIW-1:0]] <= cmd.word.high_priority_count;
                  lim_frq_r[lcnt_r[LIW-1:0]] <= cmd.word.high_priority_freq;
                  lcnt_r <= lcnt_r + LW'(1);
                end
              end
              ftb_pkg::K_CMP: begin
                if (dcnt_r == '0) begin
                  lcnt_r <= '0;
                end else begin
                  lpf_r   <= cmd.word.low_priority_freq;
                  i_r     <= '0;
                  state_r <= S_RK_I;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          dcnt_r  <= dcnt_r + CW'(1);
          state_r <= S_IDLE;
        end
        S_RK_I: state_r <= S_RK_C;
        S_RK_C: begin
          ci_rec_r  <= rd_rec_r.rec;
          ci_work_r <= rd_rec_r.work;
          j_r       <= '0;
          pv_r      <= 1'b0;
          cnt_r     <= '0;
          state_r   <= S_RK_J;
        end
        S_RK_J: begin
          if (issue) j_r <= j_r + CW'(1);
          pv_r <= issue;
          pj_r <= j_r;
          if (pv_r && ahead) cnt_r <= cnt_r + IW'(1);
          if (last_pj) state_r <= S_RK_W;
        end
        S_RK_W: begin
          i_r <= i_r + CW'(1);
          if (i_r == n_m1) begin
            j_r         <= '0;
            pv_r        <= 1'b0;
            lag_rec_r   <= 1'b0;
            ref_found_r <= 1'b0;
            any_unl_r   <= 1'b0;
            state_r     <= S_SCAN;
          end else begin
            state_r <= S_RK_I;
          end
        end
        S_SCAN: begin
          if (issue) j_r <= j_r + CW'(1);
          pv_r <= issue;
          pj_r <= j_r;
          if (pv_r) begin
            if (rd_rank_r == '0) begin
              lag_rec_r  <= rd_rec_r.rec;
              lag_work_r <= rd_rec_r.work;
              lag_time_r <= rd_rec_r.tim;
            end
            if (rd_rec_r.rec && unl_j && (!ref_found_r || rd_rank_r < best_rank_r)) begin
              ref_found_r <= 1'b1;
              best_rank_r <= rd_rank_r;
              ref_time_r  <= rd_rec_r.tim;
            end
            if (unl_j) any_unl_r <= 1'b1;
            for (int k = 0; k < MAX_LIMITS; k++) begin
              if (7'(rd_rank_r) == lim_cnt_r[k]) begin
                lpw_r[k] <= rd_rec_r.work;
                lpr_r[k] <= rd_rec_r.rec;
              end
            end
          end
          if (last_pj) state_r <= S_TGT;
        end
        S_TGT: begin
          target_r <= lag_rec_r ? (ref_found_r ? ref_time_r : lag_time_r) : '0;
          cutoff_r <= cfg.min_freq;
          group_r  <= cfg.min_freq;
          k_r      <= '0;
          i_r      <= '0;
          if (lag_rec_r) state_r <= S_LIM;
          else state_r <= any_unl_r ? S_P1R : S_EMR;
        end
        S_LIM: begin
          if (k_r == lcnt_r) begin
            state_r <= any_unl_r ? S_P1R : S_EMR;
          end else begin
            dst_r     <= 1'b1;
            div_num_r <= lag_work_r;
            div_den_r <= 32'(lim_frq_r[klim]);
            state_r   <= S_HP_W;
          end
        end
        S_HP_W: begin
          if (div_done) begin
            if (lim_cnt_r[klim] < 7'(dcnt_r)) begin
              if (!lpr_r[klim]) begin
                k_r     <= k_r + LW'(1);
                state_r <= S_LIM;
              end else begin
                hp_r      <= quo32;
                dst_r     <= 1'b1;
                div_num_r <= lpw_r[klim];
                div_den_r <= 32'(lpf_r);
                state_r   <= S_LP_W;
              end
            end else begin
              if (quo32 < target_r) begin
                target_r <= quo32;
                cutoff_r <= lpf_r;
              end
              k_r     <= k_r + LW'(1);
              state_r <= S_LIM;
            end
          end
        end
        S_LP_W: begin
          if (div_done) begin
            if (proj_lp < target_r) begin
              target_r <= proj_lp;
              cutoff_r <= lpf_r;
            end
            k_r     <= k_r + LW'(1);
            state_r <= S_LIM;
          end
        end
        S_P1R: begin
          if (i_r == dcnt_r) begin
            i_r     <= '0;
            state_r <= (group_r < cfg.max_freq) ? S_P2R : S_EMR;
          end else begin
            state_r <= S_P1D;
          end
        end
        S_P1D: begin
          if (rd_rec_r.rec) begin
            dst_r     <= 1'b1;
            div_num_r <= rd_rec_r.work;
            div_den_r <= target_r;
            state_r   <= S_P1W;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_P1R;
          end
        end
        S_P1W: begin
          if (div_done) begin
            if (d1 > group_r) group_r <= d1;
            i_r     <= i_r + CW'(1);
            state_r <= S_P1R;
          end
        end
        S_P2R: begin
          if (i_r == dcnt_r) begin
            i_r     <= '0;
            state_r <= S_EMR;
          end else begin
            state_r <= S_P2D;
          end
        end
        S_P2D: begin
          if (rd_rec_r.rec) begin
            d_r       <= rd_des_r;
            dst_r     <= 1'b1;
            div_num_r <= 48'(32'(rd_des_r) * 32'(cfg.max_freq));
            div_den_r <= 32'(group_r);
            state_r   <= S_P2W;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_P2R;
          end
        end
        S_P2W: begin
          if (div_done) begin
            i_r     <= i_r + CW'(1);
            state_r <= S_P2R;
          end
        end
        S_EMR: state_r <= S_EMD;
        S_EMD: begin
          if (!oq_full) begin
            if (i_r == n_m1) begin
              dcnt_r  <= '0;
              lcnt_r  <= '0;
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + CW'(1);
              state_r <= S_EMR;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ftb_outq.sv
// Two-word result queue between the back end and the result ports.
// Depends on ftb_pkg.
module ftb_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  ftb_pkg::out_t wr_word,
  output logic          empty,
  input  logic          pop,
  output ftb_pkg::out_t rd_word
);

  ftb_pkg::out_t ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_word = ent_r[rp_r];
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) begin
        ent_r[wp_r] <= wr_word;
        wp_r        <= ~wp_r;
      end
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

// File: rtl/frequency_time_balancer_unit.sv
// Top level of the frequency/time balancer: config registers, front, back, result queue.
// Depends on ftb_pkg, ftb_front, ftb_back, ftb_outq.
//
// channel  | ports                              | moves
// input    | in_push, in_full, in_word          | one command word
// result   | out_empty, out_pop, out_word       | one domain result word
// config   | cfg_we, cfg_idx, cfg_wdata         | one register write
//
// Domain load goes through the back end's load state; a limit load is stored from idle.
// Compute over n domains ranks and scans the domains, divides for each limit entry, divides
// for each recorded domain in up to two divider passes, then emits one result word per
// domain; the shared 48-step divider does all of these divisions.
// Reset clears counters and queues; the stores need no clearing pass.
// A full result queue stalls the back end; the two-word input queue takes words until full.
module frequency_time_balancer_unit #(
  parameter int MAX_DOMAINS = 64,
  parameter int MAX_LIMITS  = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  ftb_pkg::in_t  in_word,
  output logic          out_empty,
  input  logic          out_pop,
  output ftb_pkg::out_t out_word,
  input  logic          cfg_we,
  input  logic          cfg_idx,
  input  logic [15:0]   cfg_wdata
);

  ftb_pkg::cfg_t cfg_r;
  logic          cmd_valid, cmd_pop, oq_full, oq_push;
  ftb_pkg::cmd_t cmd;
  ftb_pkg::out_t oq_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_freq <= ftb_pkg::MIN_FREQ_RST;
      cfg_r.max_freq <= ftb_pkg::MAX_FREQ_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        ftb_pkg::CFG_MIN_FREQ: cfg_r.min_freq <= cfg_wdata;
        ftb_pkg::CFG_MAX_FREQ: cfg_r.max_freq <= cfg_wdata;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  ftb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ftb_back #(
    .MAX_DOMAINS (MAX_DOMAINS),
    .MAX_LIMITS  (MAX_LIMITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_word   (oq_word)
  );

  ftb_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .full    (oq_full),
    .wr_word (oq_word),
    .empty   (out_empty),
    .pop     (out_pop),
    .rd_word (out_word)
  );

endmodule

// File: rtl/ftb_chk.sv
// Port-level checker for the balancer top level, attached by bind.
// Depends on ftb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ftb_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_full,
  input logic          out_empty,
  input logic          out_pop,
  input ftb_pkg::out_t out_word
);

  logic [5:0]  exp_idx_r;
  logic [31:0] tgt_r;
  logic        mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
      mid_r     <= 1'b0;
    end else if (out_pop && !out_empty) begin
      if (out_word.last) begin
        exp_idx_r <= '0;
        mid_r     <= 1'b0;
      end else begin
        exp_idx_r <= out_word.domain_index + 6'd1;
        tgt_r     <= out_word.target_time;
        mid_r     <= 1'b1;
      end
    end
  end

  `ASSERT_ANY(a_rst_empty, !rst_n |=> out_empty && !in_full, "queues not empty after reset")
  `ASSERT_CLK(a_idx_seq, !out_empty |-> out_word.domain_index == exp_idx_r, "index out of order")
  `ASSERT_CLK(a_tgt_round, !out_empty && mid_r |-> out_word.target_time == tgt_r, "target moved")
  `ASSERT_CLK(a_hold, !out_empty && !out_pop |=> !out_empty && $stable(out_word), "word dropped")

endmodule

bind frequency_time_balancer_unit ftb_chk u_ftb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_word  (out_word)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for frequency_time_balancer_unit: a scoreboard class predicts
// every domain result word from the loaded records and compares it with the block.
// Depends on ftb_pkg and the RTL of the block only.
module testbench;

  localparam int QUIET_LIMIT = 60000;
  localparam int SETTLE_CYCLES = 300;

  class ftb_scoreboard;
    logic [15:0] fmin, fmax;
    logic [31:0] times[64];
    logic        recd[64];
    logic [15:0] reqf[64], achf[64], newf[64];
    int          order[64];
    int          ndom, nlim;
    logic [6:0]  lim_cnt[8];
    logic [15:0] lim_frq[8];
    logic [31:0] tgt_hold;
    logic [15:0] cut_hold;
    ftb_pkg::out_t awaited[$];
    int          errors, checked, words_in;

    function new();
      fmin = ftb_pkg::MIN_FREQ_RST;
      fmax = ftb_pkg::MAX_FREQ_RST;
      ndom = 0;
      nlim = 0;
      tgt_hold = '0;
      cut_hold = '0;
      errors = 0;
      checked = 0;
      words_in = 0;
    endfunction

    function longint unsigned work(int i);
      return longint'(times[i]) * longint'(achf[i]);
    endfunction

    function longint unsigned div_sat(longint unsigned num, longint unsigned den,
                                      longint unsigned sat);
      longint unsigned q;
      if (den == 0) return sat;
      q = num / den;
      return (q > sat) ? sat : q;
    endfunction

    function logic [15:0] clamp(longint unsigned v, logic [15:0] lo, logic [15:0] hi);
      longint unsigned x;
      x = (v < lo) ? lo : v;
      return (x > hi) ? hi : x[15:0];
    endfunction

    function bit ahead(int a, int b);
      if (recd[a] != recd[b]) return recd[a];
      if (recd[a] && work(a) != work(b)) return work(a) > work(b);
      return a < b;
    endfunction

    function void balance(logic [15:0] lp);
      int n, j, v, lag, refd, lpd;
      longint unsigned tgt, hp, lpt, proj, q, s;
      logic [15:0] cut, grp;
      bit unlimited;
      n = ndom;
      cut = fmin;
      unlimited = 0;
      for (int i = 0; i < n; i++) begin
        v = i;
        j = i;
        while (j > 0 && ahead(v, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      lag = order[0];
      if (!recd[lag]) begin
        tgt = 0;
      end else begin
        refd = lag;
        for (int i = 0; i < n; i++) begin
          if (recd[order[i]] && reqf[order[i]] >= fmax) begin
            refd = order[i];
            break;
          end
        end
        tgt = times[refd];
        for (int i = 0; i < nlim; i++) begin
          hp = div_sat(work(lag), lim_frq[i], 64'hFFFF_FFFF);
          if (lim_cnt[i] < n) begin
            lpd = order[lim_cnt[i]];
            if (!recd[lpd]) continue;
            lpt = div_sat(work(lpd), lp, 64'hFFFF_FFFF);
            proj = (lpt > hp) ? lpt : hp;
          end else begin
            proj = hp;
          end
          if (proj < tgt) begin
            tgt = proj;
            cut = lp;
          end
        end
      end
      tgt_hold = tgt[31:0];
      cut_hold = cut;
      for (int i = 0; i < n; i++) begin
        newf[i] = reqf[i];
        if (reqf[i] >= fmax) unlimited = 1;
      end
      if (!unlimited) begin
        for (int i = 0; i < n; i++) newf[i] = fmax;
        return;
      end
      grp = fmin;
      for (int i = 0; i < n; i++) begin
        if (recd[i]) begin
          q = div_sat(work(i), tgt, 64'hFFFF_FFFF_FFFF);
          newf[i] = clamp(q, fmin, fmax);
          if (newf[i] > grp) grp = newf[i];
        end
      end
      if (grp < fmax) begin
        for (int i = 0; i < n; i++) begin
          if (!recd[i]) continue;
          s = div_sat(longint'(newf[i]) * longint'(fmax), grp, 64'hFFFF_FFFF_FFFF);
          if (newf[i] > cut) newf[i] = clamp(s, fmin, fmax);
          else newf[i] = clamp(s, fmin, cut);
        end
      end
    endfunction

    function void note_input(ftb_pkg::in_t w);
      ftb_pkg::out_t r;
      words_in++;
      case (w.opcode)
        ftb_pkg::OP_DOMAIN: begin
          if (ndom < 64) begin
            times[ndom] = w.elapsed_time;
            recd[ndom] = w.time_recorded;
            reqf[ndom] = w.requested_freq;
            achf[ndom] = w.achieved_freq;
            ndom++;
          end
        end
        ftb_pkg::OP_LIMIT: begin
          if (nlim < 8) begin
            lim_cnt[nlim] = w.high_priority_count;
            lim_frq[nlim] = w.high_priority_freq;
            nlim++;
          end
        end
        ftb_pkg::OP_COMPUTE: begin
          if (ndom > 0) balance(w.low_priority_freq);
          for (int i = 0; i < ndom; i++) begin
            r.domain_index = i[5:0];
            r.desired_freq = newf[i];
            r.target_time = tgt_hold;
            r.last = (i + 1 == ndom);
            awaited.push_back(r);
          end
          ndom = 0;
          nlim = 0;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(ftb_pkg::out_t got);
      ftb_pkg::out_t want;
      checked++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected word %p", got));
        return;
      end
      want = awaited.pop_front();
      if (got.domain_index !== want.domain_index)
        report($sformatf("domain_index %0d, want %0d", got.domain_index, want.domain_index));
      if (got.desired_freq !== want.desired_freq)
        report($sformatf("domain %0d desired_freq %0d, want %0d", want.domain_index,
                         got.desired_freq, want.desired_freq));
      if (got.target_time !== want.target_time)
        report($sformatf("domain %0d target_time %0d, want %0d", want.domain_index,
                         got.target_time, want.target_time));
      if (got.last !== want.last)
        report($sformatf("domain %0d last %0b, want %0b", want.domain_index,
                         got.last, want.last));
    endtask
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_push;
  logic          in_full;
  ftb_pkg::in_t  in_word;
  logic          out_empty;
  logic          out_pop;
  ftb_pkg::out_t out_word;
  logic          cfg_we;
  logic          cfg_idx;
  logic [15:0]   cfg_wdata;

  ftb_scoreboard sb;
  int tx_idle, rx_idle;
  int quiet;
  int rounds;

  frequency_time_balancer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) sb.note_input(in_word);
      if (out_pop && !out_empty) sb.check_result(out_word);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet <= 0;
      else quiet <= quiet + 1;
      out_pop <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no word moved in %0d cycles", QUIET_LIMIT);
      $display("** frequency_time_balancer_unit: FAILED **");
      $finish;
    end
  end

  function automatic ftb_pkg::in_t noise_word(logic [1:0] op);
    ftb_pkg::in_t w;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(ftb_pkg::in_t)-1:0];
    w.opcode = op;
    return w;
  endfunction

  function automatic ftb_pkg::in_t dom_word(logic [31:0] t, logic r, logic [15:0] rq,
                                            logic [15:0] ac);
    ftb_pkg::in_t w;
    w = noise_word(ftb_pkg::OP_DOMAIN);
    w.elapsed_time = t;
    w.time_recorded = r;
    w.requested_freq = rq;
    w.achieved_freq = ac;
    return w;
  endfunction

  function automatic ftb_pkg::in_t lim_word(logic [6:0] c, logic [15:0] f);
    ftb_pkg::in_t w;
    w = noise_word(ftb_pkg::OP_LIMIT);
    w.high_priority_count = c;
    w.high_priority_freq = f;
    return w;
  endfunction

  function automatic ftb_pkg::in_t cmp_word(logic [15:0] lp);
    ftb_pkg::in_t w;
    w = noise_word(ftb_pkg::OP_COMPUTE);
    w.low_priority_freq = lp;
    return w;
  endfunction

  task send(ftb_pkg::in_t w);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task drain;
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task cfg_write(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ftb_pkg::CFG_MIN_FREQ) sb.fmin = val;
    else sb.fmax = val;
    @(posedge clk);
  endtask

  function automatic ftb_pkg::in_t rand_domain();
    logic [31:0] t;
    logic [15:0] rq, ac;
    t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1000, 2000000);
    ac = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(500, 4000));
    if ($urandom_range(0, 1)) rq = 16'($urandom_range(sb.fmax, 65535));
    else rq = 16'($urandom);
    return dom_word(t, $urandom_range(0, 9) != 0, rq, ac);
  endfunction

  task rand_round(int nd, int nl);
    int d, l;
    d = 0;
    l = 0;
    while (d < nd || l < nl) begin
      if ($urandom_range(0, 19) == 0) send(noise_word(ftb_pkg::OP_RESERVED));
      if (l < nl && (d >= nd || $urandom_range(0, 3) == 0)) begin
        send(lim_word(7'($urandom_range(0, 64)), 16'($urandom)));
        l++;
      end else begin
        send(rand_domain());
        d++;
      end
    end
    send(cmp_word(($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(500, 4000))));
    rounds++;
  endtask

  task directed;
    send(cmp_word(16'd1000));
    send(noise_word(ftb_pkg::OP_RESERVED));
    send(dom_word(32'd5000, 1'b0, 16'd1200, 16'd1500));
    send(dom_word(32'd7000, 1'b0, 16'd3100, 16'd2000));
    send(cmp_word(16'd1200));
    send(dom_word(32'd9000, 1'b1, 16'd1000, 16'd2000));
    send(dom_word(32'd8000, 1'b1, 16'd1500, 16'd2500));
    send(lim_word(7'd1, 16'd2000));
    send(cmp_word(16'd900));
    send(dom_word(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF));
    send(dom_word(32'd0, 1'b1, 16'd3000, 16'd1000));
    send(dom_word(32'd4000, 1'b1, 16'd0, 16'd0));
    send(lim_word(7'd0, 16'd0));
    send(lim_word(7'd64, 16'hFFFF));
    send(lim_word(7'd2, 16'd1));
    send(cmp_word(16'd0));
    send(dom_word(32'd6000, 1'b1, 16'd3000, 16'd2000));
    send(dom_word(32'd6000, 1'b1, 16'd2000, 16'd2000));
    send(dom_word(32'd100, 1'b0, 16'd1234, 16'd1000));
    send(lim_word(7'd2, 16'd2500));
    send(lim_word(7'd1, 16'd2600));
    send(cmp_word(16'hFFFF));
    rounds += 5;
  endtask

  task phase(int txi, int rxi, int items);
    int stop;
    tx_idle = txi;
    rx_idle = rxi;
    stop = sb.words_in + items;
    while (sb.words_in < stop) rand_round($urandom_range(1, 8), $urandom_range(0, 3));
    drain();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_word = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = ftb_pkg::CFG_MIN_FREQ;
    cfg_wdata = '0;
    quiet = 0;
    rounds = 0;
    tx_idle = 21;
    rx_idle = 77;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(ftb_pkg::CFG_MIN_FREQ, 16'd800);
    cfg_write(ftb_pkg::CFG_MAX_FREQ, 16'd3000);
    directed();
    phase(21, 77, 30);
    cfg_write(ftb_pkg::CFG_MIN_FREQ, 16'd0);
    cfg_write(ftb_pkg::CFG_MAX_FREQ, 16'hFFFF);
    phase(77, 21, 30);
    cfg_write(ftb_pkg::CFG_MIN_FREQ, 16'd2000);
    cfg_write(ftb_pkg::CFG_MAX_FREQ, 16'd1000);
    rand_round(66, 9);
    phase(0, 0, 10);
    cfg_write(ftb_pkg::CFG_MIN_FREQ, 16'hFFFF);
    cfg_write(ftb_pkg::CFG_MAX_FREQ, 16'd0);
    phase(0, 0, 10);
    cfg_write(ftb_pkg::CFG_MIN_FREQ, 16'd1200);
    cfg_write(ftb_pkg::CFG_MAX_FREQ, 16'd2800);
    phase(0, 0, 20);
    $display("covered %0d input words in %0d rounds, %0d result words checked,",
             sb.words_in, rounds, sb.checked);
    $display("five register settings, full stores and both idle patterns");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("** frequency_time_balancer_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d words still awaited", sb.errors, sb.awaited.size());
      $display("** frequency_time_balancer_unit: FAILED **");
    end
    $finish;
  end
endmodule
